// File: design/tvfi_pkg.sv
// Shared types, sizes and codes of the trilinear vector field interpolator.
// Depends on nothing; every design file but tvfi_ram refers to it by scoped names.

package tvfi_pkg;

  // Grid geometry and number formats
  localparam int GRID_X     = 16;
  localparam int GRID_Y     = 16;
  localparam int GRID_Z     = 16;
  localparam int GRID_TOTAL = GRID_X * GRID_Y * GRID_Z;
  localparam int FRAC_BITS  = 12;

  localparam int POS_W     = 16;
  localparam int INT_W     = POS_W - FRAC_BITS;
  localparam int CRD_W     = INT_W + 1;
  localparam int IDX_W     = 12;
  localparam int ADDR_W    = $clog2(GRID_TOTAL);
  localparam int SAMPLE_W  = 16;
  localparam int ENTRY_W   = 3 * SAMPLE_W;
  localparam int COMP_W    = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 2;
  localparam int COL_W     = 2;
  localparam int STEP_W    = 3;

  // Arithmetic widths
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int WXY_W  = 2 * WGT_W;
  localparam int COEF_W = 3 * FRAC_BITS + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int ACC_W  = DIFF_W + COEF_W + 1;

  localparam int SHIFT_INTERP = 3 * FRAC_BITS;
  localparam int SHIFT_GRAD   = 8;

  localparam logic signed [ACC_W-1:0] RND_INTERP = ACC_W'(1) << (SHIFT_INTERP - 1);
  localparam logic signed [ACC_W-1:0] RND_GRAD   = ACC_W'(1) << (SHIFT_GRAD - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((2 ** (COMP_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO     = -SAT_HI - ACC_W'(1);

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTERP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Z = 2'd2;
  localparam logic [CFG_W-1:0]     INV_STEP_RESET = 16'd256;

  // Per-operation control traveling down the datapath
  typedef struct packed {
    logic             valid;
    logic             grad;
    logic             base;
    logic             oor;
    logic             clear;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] column;
  } ctrl_t;

  // Flat grid address of a corner
  function automatic logic [ADDR_W-1:0] flat_index(input logic [CRD_W-1:0] x,
                                                   input logic [CRD_W-1:0] y,
                                                   input logic [CRD_W-1:0] z);
    int unsigned idx;
    idx = 32'(x) + 32'(GRID_X) * (32'(y) + 32'(GRID_Y) * 32'(z));
    return idx[ADDR_W-1:0];
  endfunction

endpackage

// File: design/tvfi_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.

module tvfi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: design/tvfi_seq.sv
// Sequencer: latches a query, walks its corner reads, forms corner weights.
// Depends on tvfi_pkg.

module tvfi_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [tvfi_pkg::KIND_W-1:0]   kind,
  input  logic [tvfi_pkg::POS_W-1:0]    pos_x,
  input  logic [tvfi_pkg::POS_W-1:0]    pos_y,
  input  logic [tvfi_pkg::POS_W-1:0]    pos_z,
  output logic                          busy,
  output logic [tvfi_pkg::ADDR_W-1:0]   raddr,
  output tvfi_pkg::ctrl_t               ctrl_o,
  output logic [tvfi_pkg::WXY_W-1:0]    wxy_o,
  output logic [tvfi_pkg::WGT_W-1:0]    wz_o
);

  logic [tvfi_pkg::POS_W-1:0]     pos_in   [3];
  logic [tvfi_pkg::CRD_W-1:0]     fl_in    [3];
  logic [tvfi_pkg::CRD_W-1:0]     ce_in    [3];
  logic [tvfi_pkg::FRAC_BITS-1:0] fr_in    [3];
  logic [2:0]                     oor_axis;

  logic [tvfi_pkg::CRD_W-1:0]     fl_r     [3];
  logic [tvfi_pkg::CRD_W-1:0]     ce_r     [3];
  logic [tvfi_pkg::FRAC_BITS-1:0] fr_r     [3];
  logic                           run_r, run_nxt;
  logic                           grad_r, oor_r;
  logic [tvfi_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [tvfi_pkg::STEP_W-1:0]    last_step;
  logic                           is_last, start_item;

  logic [2:0]                     sel;
  logic [tvfi_pkg::CRD_W-1:0]     crd      [3];
  logic [tvfi_pkg::WGT_W-1:0]     wgt      [3];
  logic [tvfi_pkg::WGT_W-1:0]     one_w;
  tvfi_pkg::ctrl_t                ctrl_nxt, ctrl_r;
  logic [tvfi_pkg::WXY_W-1:0]     wxy_r;
  logic [tvfi_pkg::WGT_W-1:0]     wz_r;

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign one_w     = tvfi_pkg::WGT_W'(1) << tvfi_pkg::FRAC_BITS;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fl_in[a] = {1'b0, pos_in[a][tvfi_pkg::POS_W-1:tvfi_pkg::FRAC_BITS]};
      fr_in[a] = pos_in[a][tvfi_pkg::FRAC_BITS-1:0];
      ce_in[a] = fl_in[a] + tvfi_pkg::CRD_W'(|fr_in[a]);
    end
    oor_axis[0] = 32'(ce_in[0]) >= 32'(tvfi_pkg::GRID_X);
    oor_axis[1] = 32'(ce_in[1]) >= 32'(tvfi_pkg::GRID_Y);
    oor_axis[2] = 32'(ce_in[2]) >= 32'(tvfi_pkg::GRID_Z);
  end

  assign start_item = accept && (kind == tvfi_pkg::KIND_INTERP || kind == tvfi_pkg::KIND_GRAD);

  // interpolate: eight corners or one flagged result; gradient: base plus three, or three flagged results
  always_comb begin
    unique case ({grad_r, oor_r})
      2'b00:   last_step = tvfi_pkg::STEP_W'(7);
      2'b01:   last_step = tvfi_pkg::STEP_W'(0);
      2'b10:   last_step = tvfi_pkg::STEP_W'(3);
      default: last_step = tvfi_pkg::STEP_W'(2);
    endcase
  end

  assign is_last = step_r == last_step;
  assign busy    = run_r && !is_last;

  always_comb begin
    run_nxt  = run_r;
    step_nxt = step_r + tvfi_pkg::STEP_W'(1);
    if (start_item) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
    end else if (run_r && is_last) begin
      run_nxt = 1'b0;
    end
  end

  // per axis: take the ceiling corner or the floor corner
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sel[a] = grad_r ? (32'(step_r) == a + 1) : step_r[a];
      crd[a] = sel[a] ? ce_r[a] : fl_r[a];
      wgt[a] = sel[a] ? {1'b0, fr_r[a]} : one_w - {1'b0, fr_r[a]};
    end
  end

  assign raddr = tvfi_pkg::flat_index(crd[0], crd[1], crd[2]);

  always_comb begin
    ctrl_nxt        = '0;
    ctrl_nxt.valid  = run_r;
    ctrl_nxt.grad   = grad_r;
    ctrl_nxt.oor    = oor_r;
    priority if (oor_r) begin
      ctrl_nxt.clear  = 1'b1;
      ctrl_nxt.emit   = 1'b1;
      ctrl_nxt.last   = is_last;
      ctrl_nxt.column = grad_r ? step_r[tvfi_pkg::COL_W-1:0] : '0;
    end else if (grad_r) begin
      ctrl_nxt.base   = step_r == '0;
      ctrl_nxt.clear  = 1'b1;
      ctrl_nxt.emit   = step_r != '0;
      ctrl_nxt.last   = is_last;
      ctrl_nxt.column = step_r[tvfi_pkg::COL_W-1:0] - tvfi_pkg::COL_W'(1);
    end else begin
      ctrl_nxt.clear  = step_r == '0;
      ctrl_nxt.emit   = is_last;
      ctrl_nxt.last   = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
      ctrl_r <= '0;
    end else begin
      run_r  <= run_nxt;
      step_r <= step_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wxy_r <= wgt[0] * wgt[1];
    wz_r  <= wgt[2];
    if (start_item) begin
      grad_r <= kind == tvfi_pkg::KIND_GRAD;
      oor_r  <= |oor_axis;
      for (int a = 0; a < 3; a++) begin
        fl_r[a] <= fl_in[a];
        ce_r[a] <= ce_in[a];
        fr_r[a] <= fr_in[a];
      end
    end
  end

  assign ctrl_o = ctrl_r;
  assign wxy_o  = wxy_r;
  assign wz_o   = wz_r;

endmodule

// File: design/tvfi_mac.sv
// Shared three-lane multiply-accumulate unit with rounding, saturation and result registers.
// Depends on tvfi_pkg.

module tvfi_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tvfi_pkg::ctrl_t                      ctrl_i,
  input  logic [tvfi_pkg::WXY_W-1:0]           wxy_i,
  input  logic [tvfi_pkg::WGT_W-1:0]           wz_i,
  input  logic [tvfi_pkg::ENTRY_W-1:0]         rdata,
  input  logic [tvfi_pkg::CFG_W-1:0]           inv_step [3],
  output logic                                 out_strobe,
  output logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_x,
  output logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_y,
  output logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_z,
  output logic [tvfi_pkg::COL_W-1:0]           out_column,
  output logic                                 out_out_of_range,
  output logic                                 out_last
);

  logic [tvfi_pkg::SAMPLE_W-1:0]        rd     [3];
  logic [tvfi_pkg::SAMPLE_W-1:0]        base_r [3];
  logic signed [tvfi_pkg::DIFF_W-1:0]   samp_nxt [3];
  logic signed [tvfi_pkg::DIFF_W-1:0]   samp_r [3];
  logic [tvfi_pkg::COEF_W-1:0]          coef_nxt, coef_r;
  logic [tvfi_pkg::WXY_W+tvfi_pkg::WGT_W-1:0] wfull;
  logic signed [tvfi_pkg::ACC_W-1:0]    prod_r [3];
  logic signed [tvfi_pkg::ACC_W-1:0]    acc_r  [3];
  logic signed [tvfi_pkg::ACC_W-1:0]    rnd;
  logic signed [tvfi_pkg::ACC_W-1:0]    shifted [3];
  logic signed [tvfi_pkg::COMP_W-1:0]   sat [3];
  tvfi_pkg::ctrl_t                      ctrl2_nxt, ctrl2_r, ctrl3_r, ctrl4_r;
  logic                                 emit;

  // stage 1: form the sample (or difference) and its coefficient
  always_comb begin
    wfull = wxy_i * wz_i;
    for (int j = 0; j < 3; j++) begin
      rd[j] = rdata[j*tvfi_pkg::SAMPLE_W +: tvfi_pkg::SAMPLE_W];
      priority if (ctrl_i.oor) begin
        samp_nxt[j] = '0;
      end else if (ctrl_i.grad) begin
        samp_nxt[j] = $signed({rd[j][tvfi_pkg::SAMPLE_W-1], rd[j]})
                    - $signed({base_r[j][tvfi_pkg::SAMPLE_W-1], base_r[j]});
      end else begin
        samp_nxt[j] = $signed({rd[j][tvfi_pkg::SAMPLE_W-1], rd[j]});
      end
    end
    if (ctrl_i.grad) begin
      coef_nxt = tvfi_pkg::COEF_W'(inv_step[ctrl_i.column]);
    end else begin
      coef_nxt = wfull[tvfi_pkg::COEF_W-1:0];
    end
    ctrl2_nxt       = ctrl_i;
    ctrl2_nxt.valid = ctrl_i.valid && !ctrl_i.base;
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.valid && ctrl_i.base) begin
      for (int j = 0; j < 3; j++) begin
        base_r[j] <= rd[j];
      end
    end
    coef_r <= coef_nxt;
    for (int j = 0; j < 3; j++) begin
      samp_r[j] <= samp_nxt[j];
      // stage 2: multiply
      prod_r[j] <= samp_r[j] * $signed({1'b0, coef_r});
    end
  end

  // stage 3: accumulate, seeded with the rounding offset
  assign rnd = ctrl3_r.grad ? tvfi_pkg::RND_GRAD : tvfi_pkg::RND_INTERP;

  always_ff @(posedge clk) begin
    if (ctrl3_r.valid) begin
      for (int j = 0; j < 3; j++) begin
        acc_r[j] <= (ctrl3_r.clear ? rnd : acc_r[j]) + prod_r[j];
      end
    end
  end

  // stage 4: scale down and clamp
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shifted[j] = ctrl4_r.grad ? (acc_r[j] >>> tvfi_pkg::SHIFT_GRAD)
                                : (acc_r[j] >>> tvfi_pkg::SHIFT_INTERP);
      priority if (shifted[j] > tvfi_pkg::SAT_HI) begin
        sat[j] = tvfi_pkg::SAT_HI[tvfi_pkg::COMP_W-1:0];
      end else if (shifted[j] < tvfi_pkg::SAT_LO) begin
        sat[j] = tvfi_pkg::SAT_LO[tvfi_pkg::COMP_W-1:0];
      end else begin
        sat[j] = shifted[j][tvfi_pkg::COMP_W-1:0];
      end
    end
  end

  assign emit = ctrl4_r.valid && ctrl4_r.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl2_r    <= '0;
      ctrl3_r    <= '0;
      ctrl4_r    <= '0;
      out_strobe <= 1'b0;
    end else begin
      ctrl2_r    <= ctrl2_nxt;
      ctrl3_r    <= ctrl2_r;
      ctrl4_r    <= ctrl3_r;
      out_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_comp_x       <= sat[0];
      out_comp_y       <= sat[1];
      out_comp_z       <= sat[2];
      out_column       <= ctrl4_r.column;
      out_out_of_range <= ctrl4_r.oor;
      out_last         <= ctrl4_r.last;
    end
  end

endmodule

// File: design/trilinear_vector_field_interp.sv
// Top level of the trilinear vector field interpolator.
// Depends on tvfi_pkg, tvfi_ram, tvfi_seq and tvfi_mac.
//
// Usage
//   Command channel: drive start with in_kind and the payload; the transaction is taken at a
//   rising edge where start is high and busy is low. in_kind selects a grid write (no
//   result), an interpolation (one result) or a gradient (three results, columns x, y, z).
//   Result channel: every result shows on the out_ ports for exactly one cycle with
//   out_strobe high; out_last marks the final result of a command. The receiver cannot
//   stall the block, so results must be taken when they appear.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0..2 = inverse grid step
//   x, y, z, unsigned Q8.8); index 3 is dropped. Write only while the block is idle.
// Timing
//   A write is taken without raising busy. An interpolation issues its eight corner reads on the single
//   grid memory port, one per cycle. A gradient issues four reads (floor corner,
//   then one ceiling corner per axis). A query whose ceiling leaves the grid
//   ignores its reads and returns flagged zeros, one result or three for a gradient. Results pass
//   the registered grid read, then the four-stage pipeline; gradient columns come back to back.
// Reset
//   rst_n (synchronous, active low) empties the sequencer and pipeline and sets the inverse
//   steps to 1.0. Grid contents survive and are undefined until written; no clearing pass.

module trilinear_vector_field_interp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tvfi_pkg::KIND_W-1:0]          in_kind,
  input  logic [tvfi_pkg::IDX_W-1:0]           in_entry_index,
  input  logic signed [tvfi_pkg::SAMPLE_W-1:0] in_value_x,
  input  logic signed [tvfi_pkg::SAMPLE_W-1:0] in_value_y,
  input  logic signed [tvfi_pkg::SAMPLE_W-1:0] in_value_z,
  input  logic [tvfi_pkg::POS_W-1:0]           in_pos_x,
  input  logic [tvfi_pkg::POS_W-1:0]           in_pos_y,
  input  logic [tvfi_pkg::POS_W-1:0]           in_pos_z,
  output logic                                 out_strobe,
  output logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_x,
  output logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_y,
  output logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_z,
  output logic [tvfi_pkg::COL_W-1:0]           out_column,
  output logic                                 out_out_of_range,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [tvfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tvfi_pkg::CFG_W-1:0]           cfg_data
);

  logic                            accept;
  logic                            ram_we;
  logic [tvfi_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [tvfi_pkg::ADDR_W-1:0]     ram_raddr;
  logic [tvfi_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [tvfi_pkg::CFG_W-1:0]      inv_step_r [3];
  tvfi_pkg::ctrl_t                 ctrl;
  logic [tvfi_pkg::WXY_W-1:0]      wxy;
  logic [tvfi_pkg::WGT_W-1:0]      wz;

  assign accept = start && !busy;

  // Grid write: drop indexes past the end of the grid
  assign ram_we    = accept && in_kind == tvfi_pkg::KIND_WRITE
                     && 32'(in_entry_index) < 32'(tvfi_pkg::GRID_TOTAL);
  assign ram_wdata = {in_value_z, in_value_y, in_value_x};

  // Inverse grid step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        inv_step_r[a] <= tvfi_pkg::INV_STEP_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvfi_pkg::CFG_INV_STEP_X: inv_step_r[0] <= cfg_data;
        tvfi_pkg::CFG_INV_STEP_Y: inv_step_r[1] <= cfg_data;
        tvfi_pkg::CFG_INV_STEP_Z: inv_step_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  tvfi_ram #(
    .WIDTH (tvfi_pkg::ENTRY_W),
    .DEPTH (tvfi_pkg::GRID_TOTAL)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_index[tvfi_pkg::ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tvfi_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .kind   (in_kind),
    .pos_x  (in_pos_x),
    .pos_y  (in_pos_y),
    .pos_z  (in_pos_z),
    .busy   (busy),
    .raddr  (ram_raddr),
    .ctrl_o (ctrl),
    .wxy_o  (wxy),
    .wz_o   (wz)
  );

  tvfi_mac u_mac (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl_i           (ctrl),
    .wxy_i            (wxy),
    .wz_i             (wz),
    .rdata            (ram_rdata),
    .inv_step         (inv_step_r),
    .out_strobe       (out_strobe),
    .out_comp_x       (out_comp_x),
    .out_comp_y       (out_comp_y),
    .out_comp_z       (out_comp_z),
    .out_column       (out_column),
    .out_out_of_range (out_out_of_range),
    .out_last         (out_last)
  );

endmodule

// File: design/tvfi_checker.sv
// Port-level checks of the trilinear vector field interpolator, bound to the top level.
// Depends on tvfi_pkg.

module tvfi_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_strobe,
  input logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_x,
  input logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_y,
  input logic signed [tvfi_pkg::COMP_W-1:0]   out_comp_z,
  input logic [tvfi_pkg::COL_W-1:0]           out_column,
  input logic                                 out_out_of_range,
  input logic                                 out_last
);

  // no result straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // a flagged result carries zero components
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_out_of_range |->
      out_comp_x == '0 && out_comp_y == '0 && out_comp_z == '0)
    else $error("out-of-range result with nonzero components");

  // the z gradient column always closes its transaction
  a_col_z_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_column == tvfi_pkg::COL_W'(2) |-> out_last)
    else $error("column z result without last");

  // gradient columns follow back to back in order
  a_col_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=>
      out_strobe && out_column == tvfi_pkg::COL_W'($past(out_column) + tvfi_pkg::COL_W'(1)))
    else $error("gradient column missing or out of order");

endmodule

bind trilinear_vector_field_interp tvfi_checker u_tvfi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_strobe       (out_strobe),
  .out_comp_x       (out_comp_x),
  .out_comp_y       (out_comp_y),
  .out_comp_z       (out_comp_z),
  .out_column       (out_column),
  .out_out_of_range (out_out_of_range),
  .out_last         (out_last)
);
